/* src/lma_pkg.sv */
// Package for the lamport_mutex_agent block: codes, state encodings and
// the command/status types shared by the controller and the datapath.
// Depends on nothing.
`default_nettype none
package lma_pkg;

	// Input operation codes
	localparam logic [2:0] OP_TICK     = 3'd0;
	localparam logic [2:0] OP_START    = 3'd1;
	localparam logic [2:0] OP_REQUEST  = 3'd2;
	localparam logic [2:0] OP_ACK      = 3'd3;
	localparam logic [2:0] OP_COOLDOWN = 3'd4;

	// Result kinds
	localparam logic [1:0] KIND_ACK      = 2'd0;
	localparam logic [1:0] KIND_REQUEST  = 2'd1;
	localparam logic [1:0] KIND_COOLDOWN = 2'd2;

	// Configuration register indexes
	localparam logic [1:0] CFG_NODE_ID        = 2'd0;
	localparam logic [1:0] CFG_NODE_COUNT     = 2'd1;
	localparam logic [1:0] CFG_RESOURCE_COUNT = 2'd2;

	localparam logic [6:0] OWNER_NONE = 7'h7F;   // -1 in two's complement
	localparam logic [6:0] ACK_SAT    = 7'h7F;   // saturated ack count
	localparam logic [2:0] MOD_LAST   = 3'd5;    // last bit step of a 6-bit dividend

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_REQ,
		PH_INSIDE,
		PH_WAIT
	} phase_t;

	typedef struct packed {
		logic [5:0] node_id;
		logic [6:0] node_count;
		logic [2:0] resource_count;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [5:0]  dest;
		logic [31:0] stamp;
		logic [1:0]  res;
		logic [7:0]  cooldown;
		logic [5:0]  owner;
	} result_t;

	typedef enum logic [4:0] {
		DP_NOP,
		DP_LOAD,
		DP_RECV,
		DP_TICK_STEP,
		DP_TICK_POST,
		DP_TICK_CHECK,
		DP_LV_BCAST,
		DP_LV_RD,
		DP_LV_ACK,
		DP_LV_DONE,
		DP_MOD_NODE,
		DP_MOD_FB,
		DP_MOD_STEP,
		DP_PICK_INIT,
		DP_PICK_STEP,
		DP_START,
		DP_REQ_GRANT,
		DP_DF_INIT,
		DP_DF_RD,
		DP_DF_CMP,
		DP_SH_INIT,
		DP_SH_RD,
		DP_SH_WR,
		DP_INS,
		DP_ACK,
		DP_FLUSH
	} dp_cmd_t;

	typedef struct packed {
		logic [2:0] op;
		logic       phase_idle;
		logic       emit_ok;
		logic       can_push;
		logic       pend_valid;
		logic       tick_hit;
		logic       idx_last;
		logic       leave_due;
		logic       mod_done;
		logic       pick_cool;
		logic       pick_last;
		logic       grant;
		logic       res_ok;
		logic       q_full;
		logic       q_empty;
		logic       scan_end;
		logic       dup;
		logic       sh_done;
		logic       lv_empty;
		logic       lv_last;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DISP,
		S_TK_SCAN,
		S_TK_POST,
		S_TK_CHK,
		S_LV_BC,
		S_LV_RD,
		S_LV_AK,
		S_LV_DONE,
		S_MOD_N,
		S_PICK_I,
		S_PICK,
		S_MOD_F,
		S_FB_SET,
		S_START,
		S_RQ,
		S_DF_RD,
		S_DF_CMP,
		S_DF_DEC,
		S_SH_RD,
		S_SH_WR,
		S_INS,
		S_AK,
		S_FLUSH
	} ctl_state_t;

endpackage
`default_nettype wire

/* src/lma_ctrl.sv */
// Controller of the lock agent: sequences datapath commands per input item.
// Depends on lma_pkg.
`default_nettype none
module lma_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire lma_pkg::dp_stat_t  stat,
	output lma_pkg::dp_cmd_t        cmd
);
	import lma_pkg::*;

	ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = DP_NOP;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd     = DP_LOAD;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				unique case (stat.op)
					OP_TICK: state_d = S_TK_SCAN;
					OP_START: begin
						if (stat.phase_idle) begin
							cmd     = DP_MOD_NODE;
							state_d = S_MOD_N;
						end else begin
							state_d = S_FLUSH;
						end
					end
					OP_REQUEST: begin
						cmd     = DP_RECV;
						state_d = S_RQ;
					end
					OP_ACK: begin
						cmd     = DP_RECV;
						state_d = S_AK;
					end
					OP_COOLDOWN: begin
						cmd     = DP_RECV;
						state_d = S_FLUSH;
					end
					default: state_d = S_FLUSH;
				endcase
			end
			S_TK_SCAN: begin
				if (!stat.tick_hit || stat.emit_ok) begin
					cmd = DP_TICK_STEP;
					if (stat.idx_last) state_d = S_TK_POST;
				end
			end
			S_TK_POST: begin
				cmd     = DP_TICK_POST;
				state_d = S_TK_CHK;
			end
			S_TK_CHK: begin
				if (stat.leave_due) begin
					state_d = S_LV_BC;
				end else begin
					cmd     = DP_TICK_CHECK;
					state_d = S_FLUSH;
				end
			end
			S_LV_BC: begin
				if (stat.emit_ok) begin
					cmd     = DP_LV_BCAST;
					state_d = stat.lv_empty ? S_LV_DONE : S_LV_RD;
				end
			end
			S_LV_RD: begin
				cmd     = DP_LV_RD;
				state_d = S_LV_AK;
			end
			S_LV_AK: begin
				if (stat.emit_ok) begin
					cmd     = DP_LV_ACK;
					state_d = stat.lv_last ? S_LV_DONE : S_LV_RD;
				end
			end
			S_LV_DONE: begin
				cmd     = DP_LV_DONE;
				state_d = S_FLUSH;
			end
			S_MOD_N: begin
				cmd = DP_MOD_STEP;
				if (stat.mod_done) state_d = S_PICK_I;
			end
			S_PICK_I: begin
				cmd     = DP_PICK_INIT;
				state_d = S_PICK;
			end
			S_PICK: begin
				if (stat.pick_cool) begin
					state_d = S_START;
				end else if (stat.pick_last) begin
					cmd     = DP_MOD_FB;
					state_d = S_MOD_F;
				end else begin
					cmd = DP_PICK_STEP;
				end
			end
			S_MOD_F: begin
				cmd = DP_MOD_STEP;
				if (stat.mod_done) state_d = S_FB_SET;
			end
			S_FB_SET: begin
				cmd     = DP_PICK_INIT;
				state_d = S_START;
			end
			S_START: begin
				cmd     = DP_START;
				state_d = S_FLUSH;
			end
			S_RQ: begin
				if (stat.grant) begin
					cmd     = DP_REQ_GRANT;
					state_d = S_FLUSH;
				end else if (!stat.res_ok || stat.q_full) begin
					state_d = S_FLUSH;
				end else begin
					cmd     = DP_DF_INIT;
					state_d = stat.q_empty ? S_INS : S_DF_RD;
				end
			end
			S_DF_RD: begin
				cmd     = DP_DF_RD;
				state_d = S_DF_CMP;
			end
			S_DF_CMP: begin
				cmd     = DP_DF_CMP;
				state_d = stat.scan_end ? S_DF_DEC : S_DF_RD;
			end
			S_DF_DEC: begin
				if (stat.dup) begin
					state_d = S_FLUSH;
				end else begin
					cmd     = DP_SH_INIT;
					state_d = S_SH_RD;
				end
			end
			S_SH_RD: begin
				if (stat.sh_done) begin
					state_d = S_INS;
				end else begin
					cmd     = DP_SH_RD;
					state_d = S_SH_WR;
				end
			end
			S_SH_WR: begin
				cmd     = DP_SH_WR;
				state_d = S_SH_RD;
			end
			S_INS: begin
				cmd     = DP_INS;
				state_d = S_FLUSH;
			end
			S_AK: begin
				cmd     = DP_ACK;
				state_d = S_FLUSH;
			end
			S_FLUSH: begin
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.can_push) begin
					cmd     = DP_FLUSH;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* src/lma_dp.sv */
// Datapath of the lock agent: protocol state, cooldowns, sorted deferred
// queues in a memory, remainder unit and result staging. Depends on lma_pkg.
`default_nettype none
module lma_dp #(
	parameter int RESOURCES   = 4,
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_NODES   = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire lma_pkg::dp_cmd_t   cmd,
	input  wire lma_pkg::cfg_t      cfg,
	input  wire logic [2:0]         op,
	input  wire logic [5:0]         src,
	input  wire logic [31:0]        stamp,
	input  wire logic [1:0]         resource,
	input  wire logic [7:0]         cooldown_value,
	input  wire logic signed [6:0]  cooldown_node,
	input  wire logic [1:0]         fallback_resource,
	input  wire logic [7:0]         stay_length,
	input  wire logic [7:0]         cooldown_draw,
	output lma_pkg::dp_stat_t       stat,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [1:0]              kind,
	output logic [5:0]              dest,
	output logic [31:0]             out_stamp,
	output logic [1:0]              out_resource,
	output logic [7:0]              out_cooldown,
	output logic [5:0]              out_owner,
	output logic                    last
);
	import lma_pkg::*;

	localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
	localparam int SW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int IW = (CW > RW) ? CW : RW;
	localparam int MW = $clog2(RESOURCES + 1) + 1;
	localparam int AW = RW + SW;
	localparam int MEM_DEPTH = RESOURCES << SW;

	typedef struct packed {
		logic [5:0]  src;
		logic [31:0] stamp;
	} entry_t;

	// Latched input item
	logic [2:0]  op_q;
	logic [5:0]  src_q;
	logic [31:0] stamp_q;
	logic [1:0]  res_q;
	logic [7:0]  cval_q;
	logic [6:0]  cown_q;
	logic [1:0]  fb_q;
	logic [7:0]  stay_q;
	logic [7:0]  draw_q;

	// Protocol state
	phase_t          phase_q;
	logic [31:0]     clock_q;
	logic [RW-1:0]   wanted_q;
	logic [31:0]     rstamp_q;
	logic [6:0]      ack_q;
	logic [31:0]     entry_q;
	logic [7:0]      hold_q;
	logic [7:0]      cd_q     [RESOURCES];
	logic [6:0]      holder_q [RESOURCES];
	logic [CW-1:0]   dcnt_q   [RESOURCES];

	// Sequencing registers
	logic [IW-1:0] idx_q;
	logic [MW-1:0] pick_i_q;
	logic [CW-1:0] rank_q;
	logic          dup_q;
	logic          any_q;
	logic [5:0]    mod_op_q;
	logic [MW-1:0] rem_q;
	logic [2:0]    mod_cnt_q;

	// Result staging and output register
	result_t pend_q, outr_q, new_res;
	logic    pend_v_q, out_v_q, out_last_q;

	// Deferred queue memory
	entry_t mem [MEM_DEPTH];
	entry_t rd_q, wdata;
	logic   we, re;
	logic [AW-1:0] waddr, raddr;

	logic [MW-1:0] m_eff;
	logic [6:0]    need;
	logic [RW-1:0] idx_r, res_r;
	logic [IW-1:0] idx_dec;
	logic [CW-1:0] cur_cnt, w_cnt;
	logic [6:0]    node_w, ack_n;
	logic [MW-1:0] rem_sh, rem_nx;
	logic          tick_hit, res_match, grant, res_ok, do_emit, push_out, can_push, key_lt;

	assign m_eff = (cfg.resource_count == 3'd0) ? MW'(1) :
		(32'(cfg.resource_count) > RESOURCES) ? MW'(RESOURCES) : MW'(cfg.resource_count);
	assign need = (cfg.node_count < 7'd2) ? 7'd1 :
		(32'(cfg.node_count) > MAX_NODES) ? 7'(MAX_NODES - 1) : cfg.node_count - 7'd1;

	assign idx_r    = idx_q[RW-1:0];
	assign res_r    = RW'(res_q);
	assign idx_dec  = idx_q - IW'(1);
	assign cur_cnt  = dcnt_q[res_r];
	assign w_cnt    = dcnt_q[wanted_q];
	assign node_w   = {1'b0, cfg.node_id};
	assign ack_n    = (ack_q == ACK_SAT) ? ACK_SAT : ack_q + 7'd1;
	assign tick_hit = (cd_q[idx_r] != 8'd0) && (holder_q[idx_r] == node_w);
	assign res_match = 32'(res_q) == 32'(wanted_q);
	assign res_ok   = 32'(res_q) < RESOURCES;
	assign grant    = (phase_q == PH_IDLE) || !res_match ||
		((phase_q == PH_REQ) && ((stamp_q < rstamp_q) ||
		((stamp_q == rstamp_q) && (src_q < cfg.node_id))));
	assign key_lt   = (rd_q.stamp < stamp_q) || ((rd_q.stamp == stamp_q) && (rd_q.src < src_q));

	assign rem_sh = {rem_q[MW-2:0], mod_op_q[5]};
	assign rem_nx = (rem_sh >= m_eff) ? rem_sh - m_eff : rem_sh;

	assign can_push = !out_v_q || !out_stall;

	always_comb begin
		new_res = '0;
		do_emit = 1'b0;
		case (cmd)
			DP_TICK_STEP: begin
				do_emit          = tick_hit;
				new_res.kind     = KIND_COOLDOWN;
				new_res.stamp    = clock_q;
				new_res.res      = 2'(idx_r);
				new_res.cooldown = cd_q[idx_r] - 8'd1;
				new_res.owner    = cfg.node_id;
			end
			DP_LV_BCAST: begin
				do_emit          = 1'b1;
				new_res.kind     = KIND_COOLDOWN;
				new_res.stamp    = clock_q;
				new_res.res      = 2'(wanted_q);
				new_res.cooldown = draw_q;
				new_res.owner    = cfg.node_id;
			end
			DP_LV_ACK: begin
				do_emit       = 1'b1;
				new_res.kind  = KIND_ACK;
				new_res.dest  = rd_q.src;
				new_res.stamp = clock_q;
				new_res.res   = 2'(wanted_q);
			end
			DP_START: begin
				do_emit       = 1'b1;
				new_res.kind  = KIND_REQUEST;
				new_res.stamp = clock_q + 32'd1;
				new_res.res   = 2'(idx_r);
			end
			DP_REQ_GRANT: begin
				do_emit       = 1'b1;
				new_res.kind  = KIND_ACK;
				new_res.dest  = src_q;
				new_res.stamp = clock_q;
				new_res.res   = res_q;
			end
			default: ;
		endcase
	end

	assign push_out = (cmd == DP_FLUSH) || (do_emit && pend_v_q);

	// Memory port control
	always_comb begin
		we    = 1'b0;
		re    = 1'b0;
		waddr = {res_r, idx_q[SW-1:0]};
		raddr = {res_r, idx_q[SW-1:0]};
		wdata = rd_q;
		case (cmd)
			DP_DF_RD: re = 1'b1;
			DP_SH_RD: begin
				re    = 1'b1;
				raddr = {res_r, idx_dec[SW-1:0]};
			end
			DP_LV_RD: begin
				re    = 1'b1;
				raddr = {wanted_q, idx_q[SW-1:0]};
			end
			DP_SH_WR: we = 1'b1;
			DP_INS: begin
				we    = 1'b1;
				waddr = {res_r, rank_q[SW-1:0]};
				wdata = '{src: src_q, stamp: stamp_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		if (re) rd_q <= mem[raddr];
	end

	// Input latch and result payload
	always_ff @(posedge clk) begin
		if (cmd == DP_LOAD) begin
			op_q    <= op;
			src_q   <= src;
			stamp_q <= stamp;
			res_q   <= resource;
			cval_q  <= cooldown_value;
			cown_q  <= cooldown_node;
			fb_q    <= fallback_resource;
			stay_q  <= stay_length;
			draw_q  <= cooldown_draw;
		end
		if (push_out) begin
			outr_q     <= pend_q;
			out_last_q <= (cmd == DP_FLUSH);
		end
		if (do_emit) pend_q <= new_res;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			pend_v_q <= 1'b0;
		end else begin
			if (push_out) begin
				out_v_q <= 1'b1;
			end else if (!out_stall) begin
				out_v_q <= 1'b0;
			end
			if (do_emit) begin
				pend_v_q <= 1'b1;
			end else if (cmd == DP_FLUSH) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Protocol state and sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			clock_q   <= '0;
			wanted_q  <= '0;
			rstamp_q  <= '1;
			ack_q     <= '0;
			entry_q   <= '0;
			hold_q    <= '0;
			for (int r = 0; r < RESOURCES; r++) begin
				cd_q[r]     <= '0;
				holder_q[r] <= OWNER_NONE;
				dcnt_q[r]   <= '0;
			end
			idx_q     <= '0;
			pick_i_q  <= '0;
			rank_q    <= '0;
			dup_q     <= 1'b0;
			any_q     <= 1'b0;
			mod_op_q  <= '0;
			rem_q     <= '0;
			mod_cnt_q <= '0;
		end else begin
			case (cmd)
				DP_LOAD: begin
					idx_q <= '0;
					any_q <= 1'b0;
				end
				DP_RECV: begin
					clock_q <= ((stamp_q > clock_q) ? stamp_q : clock_q) + 32'd1;
					if (op_q == OP_COOLDOWN && res_ok) begin
						cd_q[res_r]     <= cval_q;
						holder_q[res_r] <= cown_q;
					end
				end
				DP_TICK_STEP: begin
					if (tick_hit) begin
						cd_q[idx_r] <= cd_q[idx_r] - 8'd1;
						if (cd_q[idx_r] == 8'd1) holder_q[idx_r] <= OWNER_NONE;
						any_q <= 1'b1;
					end
					idx_q <= idx_q + IW'(1);
				end
				DP_TICK_POST: begin
					clock_q <= clock_q + 32'(any_q) + 32'(phase_q == PH_INSIDE);
				end
				DP_TICK_CHECK: begin
					if (phase_q == PH_WAIT && cd_q[wanted_q] == 8'd0 && ack_q == need) begin
						phase_q <= PH_INSIDE;
						entry_q <= clock_q;
						hold_q  <= stay_q;
					end
				end
				DP_LV_BCAST: begin
					cd_q[wanted_q]     <= draw_q;
					holder_q[wanted_q] <= node_w;
					idx_q              <= '0;
				end
				DP_LV_ACK: idx_q <= idx_q + IW'(1);
				DP_LV_DONE: begin
					dcnt_q[wanted_q] <= '0;
					phase_q  <= PH_IDLE;
					wanted_q <= '0;
					rstamp_q <= '1;
					ack_q    <= '0;
				end
				DP_MOD_NODE: begin
					mod_op_q  <= cfg.node_id;
					rem_q     <= '0;
					mod_cnt_q <= '0;
				end
				DP_MOD_FB: begin
					mod_op_q  <= {4'd0, fb_q};
					rem_q     <= '0;
					mod_cnt_q <= '0;
				end
				DP_MOD_STEP: begin
					rem_q     <= rem_nx;
					mod_op_q  <= {mod_op_q[4:0], 1'b0};
					mod_cnt_q <= mod_cnt_q + 3'd1;
				end
				DP_PICK_INIT: begin
					idx_q    <= IW'(rem_q);
					pick_i_q <= '0;
				end
				DP_PICK_STEP: begin
					idx_q    <= (32'(idx_q) + 1 == 32'(m_eff)) ? '0 : idx_q + IW'(1);
					pick_i_q <= pick_i_q + MW'(1);
				end
				DP_START: begin
					wanted_q <= idx_r;
					phase_q  <= PH_REQ;
					clock_q  <= clock_q + 32'd1;
					rstamp_q <= clock_q + 32'd1;
					ack_q    <= '0;
				end
				DP_DF_INIT: begin
					idx_q  <= '0;
					rank_q <= '0;
					dup_q  <= 1'b0;
				end
				DP_DF_CMP: begin
					if (rd_q.src == src_q && rd_q.stamp == stamp_q) dup_q <= 1'b1;
					if (key_lt) rank_q <= rank_q + CW'(1);
					idx_q <= idx_q + IW'(1);
				end
				DP_SH_INIT: idx_q <= IW'(cur_cnt);
				DP_SH_WR:   idx_q <= idx_dec;
				DP_INS:     dcnt_q[res_r] <= cur_cnt + CW'(1);
				DP_ACK: begin
					if (phase_q == PH_REQ && res_match) begin
						ack_q <= ack_n;
						if (ack_n == need) begin
							if (cd_q[wanted_q] == 8'd0) begin
								phase_q <= PH_INSIDE;
								entry_q <= clock_q;
								hold_q  <= stay_q;
							end else begin
								phase_q <= PH_WAIT;
							end
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		stat            = '0;
		stat.op         = op_q;
		stat.phase_idle = (phase_q == PH_IDLE);
		stat.can_push   = can_push;
		stat.pend_valid = pend_v_q;
		stat.emit_ok    = !pend_v_q || can_push;
		stat.tick_hit   = tick_hit;
		stat.idx_last   = (32'(idx_q) + 1) == 32'(m_eff);
		stat.leave_due  = (phase_q == PH_INSIDE) && ((clock_q - entry_q) >= {24'd0, hold_q});
		stat.mod_done   = (mod_cnt_q == MOD_LAST);
		stat.pick_cool  = (cd_q[idx_r] == 8'd0);
		stat.pick_last  = (32'(pick_i_q) + 1) == 32'(m_eff);
		stat.grant      = grant;
		stat.res_ok     = res_ok;
		stat.q_full     = (cur_cnt == CW'(QUEUE_DEPTH));
		stat.q_empty    = (cur_cnt == '0);
		stat.scan_end   = (32'(idx_q) + 1) == 32'(cur_cnt);
		stat.dup        = dup_q;
		stat.sh_done    = (32'(idx_q) == 32'(rank_q));
		stat.lv_empty   = (w_cnt == '0);
		stat.lv_last    = (32'(idx_q) + 1) == 32'(w_cnt);
	end

	assign out_valid    = out_v_q;
	assign kind         = outr_q.kind;
	assign dest         = outr_q.dest;
	assign out_stamp    = outr_q.stamp;
	assign out_resource = outr_q.res;
	assign out_cooldown = outr_q.cooldown;
	assign out_owner    = outr_q.owner;
	assign last         = out_last_q;

endmodule
`default_nettype wire

/* src/lamport_mutex_agent.sv */
// Items are handled one at a time. A deferred request walks its resource's queue to compare
// (a read and a compare per entry), then shifts the entries behind its place (a read and a
// write each), and a leave reads each deferred entry before sending its ack. The next item is
// taken once the last result of the current one has moved to the output register.
// Results leave through one output register, so a stalled consumer holds the sequencer.
// Reset (arst_n low, asynchronous): protocol idle, clock zero, cooldowns clear, queues empty.
`default_nettype none
module lamport_mutex_agent #(
	parameter int RESOURCES   = 4,
	parameter int QUEUE_DEPTH = 16,
	parameter int MAX_NODES   = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// input item channel
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        op,
	input  wire logic [5:0]        src,
	input  wire logic [31:0]       stamp,
	input  wire logic [1:0]        resource,
	input  wire logic [7:0]        cooldown_value,
	input  wire logic signed [6:0] cooldown_node,
	input  wire logic [1:0]        fallback_resource,
	input  wire logic [7:0]        stay_length,
	input  wire logic [7:0]        cooldown_draw,
	// result channel
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [1:0]             kind,
	output logic [5:0]             dest,
	output logic [31:0]            out_stamp,
	output logic [1:0]             out_resource,
	output logic [7:0]             out_cooldown,
	output logic [5:0]             out_owner,
	output logic                   last,
	// configuration write channel
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [6:0]        cfg_data
);
	import lma_pkg::*;

	cfg_t     cfg_q;
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// Register writes are always taken; writes to an unused index drop.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_id        <= 6'd0;
			cfg_q.node_count     <= 7'd4;
			cfg_q.resource_count <= 3'd4;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_NODE_ID:        cfg_q.node_id        <= cfg_data[5:0];
				CFG_NODE_COUNT:     cfg_q.node_count     <= cfg_data;
				CFG_RESOURCE_COUNT: cfg_q.resource_count <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	// Controller: one state per step of an item; holds while results back up.
	lma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Datapath: state, queue memory, remainder unit and the result stage.
	// The first result of an item is staged; each later one advances the
	// staged one to the output register, and the final transfer carries last.
	lma_dp #(
		.RESOURCES   (RESOURCES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.MAX_NODES   (MAX_NODES)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.cfg               (cfg_q),
		.op                (op),
		.src               (src),
		.stamp             (stamp),
		.resource          (resource),
		.cooldown_value    (cooldown_value),
		.cooldown_node     (cooldown_node),
		.fallback_resource (fallback_resource),
		.stay_length       (stay_length),
		.cooldown_draw     (cooldown_draw),
		.stat              (stat),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.kind              (kind),
		.dest              (dest),
		.out_stamp         (out_stamp),
		.out_resource      (out_resource),
		.out_cooldown      (out_cooldown),
		.out_owner         (out_owner),
		.last              (last)
	);

endmodule
`default_nettype wire

/* src/lma_checker.sv */
// Port-level checks for lamport_mutex_agent, bound to the top level.
// Depends on lma_pkg.
`default_nettype none
module lma_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  kind,
	input wire logic [31:0] out_stamp,
	input wire logic [7:0]  out_cooldown,
	input wire logic [5:0]  out_owner
);
	import lma_pkg::*;

	// an accepted item keeps the input side busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken twice in a row");

	// a new result appears only after a busy cycle
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a busy cycle");

	a_ack_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_ACK |-> out_cooldown == 8'd0 && out_owner == 6'd0)
		else $error("ack carries cooldown fields");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_stamp) && $stable(kind))
		else $error("stalled result changed");

endmodule

bind lamport_mutex_agent lma_checker u_lma_checker (.*);
`default_nettype wire

/* dv/lamport_mutex_agent_test.sv */
// Self-checking testbench for lamport_mutex_agent: drives lock-protocol events, predicts the
// messages the node sends and compares each output transfer field by field.
// Depends on lma_pkg and the lamport_mutex_agent RTL.
`timescale 1ns / 100ps
module lamport_mutex_agent_test;
	import lma_pkg::*;

	localparam int NRES   = 4;
	localparam int QDEPTH = 16;
	localparam int QUIET  = 100;     // cycles allowed for a step that sends nothing
	localparam int STALL_LIMIT = 5000;
	localparam int ITEMS  = 150;

	typedef struct {
		logic [2:0]        op;
		logic [5:0]        src;
		logic [31:0]       stamp;
		logic [1:0]        res;
		logic [7:0]        cval;
		logic signed [6:0] owner;
		logic [1:0]        fb;
		logic [7:0]        stay;
		logic [7:0]        draw;
	} agent_ev_t;

	typedef struct packed {
		result_t body;
		logic    last;
	} msg_t;

	logic clk, arst_n;
	logic in_valid, in_stall;
	logic [2:0] op;
	logic [5:0] src;
	logic [31:0] stamp;
	logic [1:0] resource;
	logic [7:0] cooldown_value;
	logic signed [6:0] cooldown_node;
	logic [1:0] fallback_resource;
	logic [7:0] stay_length, cooldown_draw;
	logic out_valid, out_stall;
	logic [1:0] kind;
	logic [5:0] dest;
	logic [31:0] out_stamp;
	logic [1:0] out_resource;
	logic [7:0] out_cooldown;
	logic [5:0] out_owner;
	logic last;
	logic cfg_valid, cfg_ready;
	logic [1:0] cfg_index;
	logic [6:0] cfg_data;

	lamport_mutex_agent DUT (.*);

	// Predicted node state and register copies
	logic [5:0]  my_id;
	logic [6:0]  n_nodes;
	logic [2:0]  n_res;
	phase_t      lk_phase;
	logic [31:0] lamport;
	int          wanted;
	logic [31:0] req_stamp;
	int          acks;
	logic [31:0] entry_clk;
	logic [7:0]  hold_len;
	logic [7:0]  cd_left [NRES];
	int          cd_holder [NRES];
	logic [5:0]  wait_src [NRES][QDEPTH];
	logic [31:0] wait_stamp [NRES][QDEPTH];
	int          wait_cnt [NRES];

	msg_t pending_msgs[$];
	int   mismatches;
	int   items_sent;
	bit   steady;          // no idling on either side while set
	int   holdoff_req, holdoff_seen, holdoff_left;
	int   quiet_cycles;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic void note_mismatch(string what, msg_t exp_m, msg_t act_m);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s: expected kind %0d dest %0d stamp %h res %0d cd %0d ",
				what, exp_m.body.kind, exp_m.body.dest, exp_m.body.stamp, exp_m.body.res,
				exp_m.body.cooldown,
				"own %0d last %0d, got kind %0d dest %0d stamp %h res %0d cd %0d ",
				exp_m.body.owner, exp_m.last,
				act_m.body.kind, act_m.body.dest, act_m.body.stamp, act_m.body.res,
				act_m.body.cooldown,
				"own %0d last %0d", act_m.body.owner, act_m.last);
	endfunction

	function automatic void push_msg(logic [1:0] k, logic [5:0] d, logic [31:0] s,
		logic [1:0] r, logic [7:0] c, logic [5:0] o);
		msg_t m;
		m.body.kind = k; m.body.dest = d; m.body.stamp = s;
		m.body.res = r; m.body.cooldown = c; m.body.owner = o;
		m.last = 1'b0;
		pending_msgs.push_back(m);
	endfunction

	function automatic int active_res();
		if (n_res < 1) return 1;
		if (n_res > NRES) return NRES;
		return int'(n_res);
	endfunction

	function automatic int acks_needed();
		if (n_nodes < 2) return 1;
		if (n_nodes > 64) return 63;
		return int'(n_nodes) - 1;
	endfunction

	function automatic void go_idle();
		lk_phase = PH_IDLE;
		wanted = -1;
		req_stamp = 32'hFFFF_FFFF;
		acks = 0;
	endfunction

	function automatic void enter_res(logic [7:0] stay);
		lk_phase = PH_INSIDE;
		entry_clk = lamport;
		hold_len = stay;
	endfunction

	function automatic void bump_on_receipt(logic [31:0] s);
		if (s > lamport) lamport = s;
		lamport = lamport + 32'd1;
	endfunction

	// Leave the held resource: set our cooldown, broadcast it, then release the
	// deferred requesters in (stamp, source) order.
	function automatic void leave_res(logic [7:0] draw);
		int r, i, j;
		logic [5:0] s;
		logic [31:0] t;
		if (wanted < 0 || wanted >= NRES) begin
			go_idle();
			return;
		end
		r = wanted;
		cd_left[r] = draw;
		cd_holder[r] = int'(my_id);
		push_msg(KIND_COOLDOWN, 6'd0, lamport, 2'(r), draw, my_id);
		for (i = 1; i < wait_cnt[r]; i++) begin
			s = wait_src[r][i];
			t = wait_stamp[r][i];
			j = i;
			while (j > 0 && (wait_stamp[r][j-1] > t ||
					(wait_stamp[r][j-1] == t && wait_src[r][j-1] > s))) begin
				wait_src[r][j] = wait_src[r][j-1];
				wait_stamp[r][j] = wait_stamp[r][j-1];
				j--;
			end
			wait_src[r][j] = s;
			wait_stamp[r][j] = t;
		end
		for (i = 0; i < wait_cnt[r]; i++)
			push_msg(KIND_ACK, wait_src[r][i], lamport, 2'(r), 8'd0, 6'd0);
		wait_cnt[r] = 0;
		go_idle();
	endfunction

	function automatic void defer_req(int r, logic [5:0] s, logic [31:0] t);
		if (wait_cnt[r] >= QDEPTH) return;
		for (int i = 0; i < wait_cnt[r]; i++)
			if (wait_src[r][i] == s && wait_stamp[r][i] == t) return;
		wait_src[r][wait_cnt[r]] = s;
		wait_stamp[r][wait_cnt[r]] = t;
		wait_cnt[r]++;
	endfunction

	// Advance the predicted node by one accepted event and queue what it sends.
	function automatic void predict_messages(agent_ev_t e);
		int m, need, pick, r, base;
		bit any, grant;
		m = active_res();
		need = acks_needed();
		base = pending_msgs.size();
		case (e.op)
			OP_TICK: begin
				any = 0;
				for (r = 0; r < m; r++) begin
					if (cd_left[r] > 0 && cd_holder[r] == int'(my_id)) begin
						any = 1;
						cd_left[r]--;
						if (cd_left[r] == 0) cd_holder[r] = -1;
						push_msg(KIND_COOLDOWN, 6'd0, lamport, 2'(r), cd_left[r], my_id);
					end
				end
				if (any) lamport = lamport + 32'd1;
				if (lk_phase == PH_INSIDE) begin
					lamport = lamport + 32'd1;
					if (lamport - entry_clk >= {24'd0, hold_len}) leave_res(e.draw);
				end else if (lk_phase == PH_WAIT) begin
					if (wanted >= 0 && cd_left[wanted] == 0 && acks == need)
						enter_res(e.stay);
				end
			end
			OP_START: begin
				if (lk_phase == PH_IDLE) begin
					pick = -1;
					for (int i = 0; i < m; i++) begin
						r = (int'(my_id) + i) % m;
						if (cd_left[r] == 0) begin
							pick = r;
							break;
						end
					end
					if (pick < 0) pick = int'(e.fb) % m;
					wanted = pick;
					lk_phase = PH_REQ;
					lamport = lamport + 32'd1;
					req_stamp = lamport;
					acks = 0;
					push_msg(KIND_REQUEST, 6'd0, req_stamp, 2'(pick), 8'd0, 6'd0);
				end
			end
			OP_REQUEST: begin
				bump_on_receipt(e.stamp);
				if (lk_phase == PH_IDLE || int'(e.res) != wanted) grant = 1;
				else if (lk_phase == PH_REQ)
					grant = e.stamp < req_stamp || (e.stamp == req_stamp && e.src < my_id);
				else grant = 0;
				if (grant) push_msg(KIND_ACK, e.src, lamport, e.res, 8'd0, 6'd0);
				else defer_req(int'(e.res), e.src, e.stamp);
			end
			OP_ACK: begin
				bump_on_receipt(e.stamp);
				if (lk_phase == PH_REQ && int'(e.res) == wanted) begin
					acks++;
					if (acks == need) begin
						if (cd_left[wanted] == 0) enter_res(e.stay);
						else lk_phase = PH_WAIT;
					end
				end
			end
			OP_COOLDOWN: begin
				bump_on_receipt(e.stamp);
				cd_left[e.res] = e.cval;
				cd_holder[e.res] = int'(e.owner);
			end
			default: ;
		endcase
		if (pending_msgs.size() > base) pending_msgs[$].last = 1'b1;
	endfunction

	function automatic agent_ev_t rand_ev(logic [2:0] code);
		agent_ev_t e;
		e.op = code;
		e.src = 6'($urandom);
		e.stamp = $urandom;
		e.res = 2'($urandom);
		e.cval = 8'($urandom);
		e.owner = 7'($urandom);
		e.fb = 2'($urandom);
		e.stay = 8'($urandom_range(3, 0));
		e.draw = 8'($urandom);
		return e;
	endfunction

	// Present one event and hold it until the block takes the transfer.
	task automatic send_event(agent_ev_t e);
		while (!steady && $urandom_range(99) < 11) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op <= e.op; src <= e.src; stamp <= e.stamp; resource <= e.res;
		cooldown_value <= e.cval; cooldown_node <= e.owner;
		fallback_resource <= e.fb; stay_length <= e.stay; cooldown_draw <= e.draw;
		do @(posedge clk); while (!(in_valid && !in_stall));
		predict_messages(e);
		items_sent++;
	endtask

	// Drain every expected message, then give a silent step time to finish.
	task automatic wait_drained();
		in_valid <= 1'b0;
		wait (pending_msgs.size() == 0);
		repeat (QUIET) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [6:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!(cfg_valid && cfg_ready));
		cfg_valid <= 1'b0;
		case (idx)
			CFG_NODE_ID:        my_id = value[5:0];
			CFG_NODE_COUNT:     n_nodes = value;
			CFG_RESOURCE_COUNT: n_res = value[2:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [6:0] id, logic [6:0] nodes, logic [6:0] res_cnt);
		wait_drained();
		write_reg(CFG_NODE_ID, id);
		write_reg(CFG_NODE_COUNT, nodes);
		write_reg(CFG_RESOURCE_COUNT, res_cnt);
	endtask

	// One well-formed lock cycle: request, collect acks, hold, leave; with
	// stray traffic mixed in so deferred queues and cooldowns get exercised.
	task automatic run_session();
		agent_ev_t e;
		int guard;
		e = rand_ev(OP_START);
		send_event(e);
		if (lk_phase != PH_REQ) return;
		if ($urandom_range(99) < 30) begin
			e = rand_ev(OP_COOLDOWN);
			e.res = 2'(wanted);
			e.cval = 8'($urandom_range(4, 1));
			e.owner = {1'b0, my_id};
			e.stamp = $urandom_range(64);
			send_event(e);
		end
		for (int a = acks_needed(); a > 0 && lk_phase == PH_REQ; a--) begin
			if ($urandom_range(99) < 25) begin
				e = rand_ev(OP_REQUEST);
				if ($urandom_range(1)) e.res = 2'(wanted);
				send_event(e);
			end
			e = rand_ev(OP_ACK);
			e.res = 2'(wanted);
			e.stamp = lamport + $urandom_range(8);
			send_event(e);
		end
		guard = 0;
		while (lk_phase != PH_IDLE && guard < 40) begin
			if ($urandom_range(99) < 40) begin
				e = rand_ev(OP_REQUEST);
				if ($urandom_range(99) < 80) e.res = 2'(wanted);
				e.stamp = $urandom_range(1) ? $urandom : lamport + $urandom_range(16);
				send_event(e);
			end
			if ($urandom_range(99) < 8) send_event(rand_ev(3'($urandom_range(7))));
			e = rand_ev(OP_TICK);
			if ($urandom_range(99) < 10) e.draw = 8'd0;
			send_event(e);
			guard++;
		end
	endtask

	task automatic test_directed();
		agent_ev_t e;
		send_event(rand_ev(OP_TICK));
		send_event(rand_ev(3'd5));
		send_event(rand_ev(3'd6));
		send_event(rand_ev(3'd7));
		// own cooldown on resource 3; receipt stamp wraps the clock
		e = rand_ev(OP_COOLDOWN); e.res = 2'd3; e.cval = 8'd2; e.owner = 7'sd0;
		e.stamp = 32'hFFFF_FFFF;
		send_event(e);
		e = rand_ev(OP_START); e.fb = 2'd3;
		send_event(e);
		send_event(rand_ev(OP_START));                 // not idle: ignored
		e = rand_ev(OP_REQUEST); e.res = 2'(wanted); e.src = 6'd5; e.stamp = 32'd0;
		send_event(e);                                  // older stamp wins: ack
		e = rand_ev(OP_REQUEST); e.res = 2'(wanted); e.src = 6'd63;
		e.stamp = 32'hFFFF_FFF0;
		send_event(e);                                  // younger: deferred
		send_event(e);                                  // duplicate: dropped
		e = rand_ev(OP_REQUEST); e.res = 2'(wanted + 1); e.stamp = 32'd3;
		send_event(e);                                  // other resource: ack
		e = rand_ev(OP_ACK); e.res = 2'(wanted + 1);
		send_event(e);                                  // wrong resource ack
		repeat (3) begin
			e = rand_ev(OP_ACK); e.res = 2'(wanted); e.stamp = 32'd0; e.stay = 8'd0;
			send_event(e);
		end
		e = rand_ev(OP_REQUEST); e.res = 2'(wanted); e.src = 6'd1; e.stamp = 32'd5;
		send_event(e);                                  // deferred while inside
		e = rand_ev(OP_TICK); e.draw = 8'd0;
		send_event(e);                                  // zero stay: leave now
		e = rand_ev(OP_COOLDOWN); e.res = 2'd2; e.cval = 8'hFF; e.owner = -7'sd1;
		send_event(e);
		e = rand_ev(OP_COOLDOWN); e.res = 2'd1; e.cval = 8'd1; e.owner = 7'sd63;
		send_event(e);
		repeat (3) send_event(rand_ev(OP_TICK));
	endtask

	// Push more distinct requests than a queue holds while inside.
	task automatic test_queue_overflow();
		agent_ev_t e;
		configure(7'd9, 7'd2, 7'd2);
		send_event(rand_ev(OP_START));
		e = rand_ev(OP_ACK); e.res = 2'(wanted); e.stay = 8'd200;
		send_event(e);
		for (int i = 0; i < QDEPTH + 4; i++) begin
			e = rand_ev(OP_REQUEST); e.res = 2'(wanted); e.stamp = $urandom_range(32);
			send_event(e);
		end
		e = rand_ev(OP_REQUEST); e.res = 2'(wanted); e.stamp = 32'hFFFF_FFF0;
		send_event(e);                                  // jump clock past hold time
		send_event(rand_ev(OP_TICK));
	endtask

	// Hold off the receiver long enough for the block to back up its input.
	task automatic test_backpressure();
		configure(7'd3, 7'd3, 7'd4);
		holdoff_req++;
		repeat (2) run_session();
	endtask

	task automatic test_config_sweep();
		configure(7'd63, 7'd2, 7'd1);
		repeat (2) run_session();
		configure(7'd17, 7'd0, 7'd0);                   // below range: clamped
		repeat (2) run_session();
		configure(7'd42, 7'd3, 7'd7);                   // above range: clamped
		run_session();
		wait_drained();
		write_reg(2'd3, 7'h55);                         // unused index
		configure(7'd5, 7'd5, 7'd3);
		steady = 1;                                     // stretch with no idling
		repeat (2) run_session();
		steady = 0;
	endtask

	task automatic test_random();
		while (items_sent < ITEMS) begin
			if ($urandom_range(99) < 15)
				configure(7'($urandom_range(63)), 7'($urandom_range(6, 2)),
					7'($urandom_range(4, 1)));
			if ($urandom_range(99) < 80) run_session();
			else send_event(rand_ev(3'($urandom_range(7))));
		end
	endtask

	// Receiver: random stalls, a steady stretch, and a counted long hold-off.
	always @(posedge clk) begin
		if (holdoff_left > 0) begin
			out_stall <= 1'b1;
			holdoff_left <= holdoff_left - 1;
		end else if (holdoff_req != holdoff_seen) begin
			holdoff_seen <= holdoff_req;
			holdoff_left <= 400;
			out_stall <= 1'b1;
		end else begin
			out_stall <= !steady && ($urandom_range(99) < 11);
		end
	end

	// Check every output transfer against the oldest expected message.
	always @(posedge clk) begin
		msg_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got.body.kind = kind; got.body.dest = dest; got.body.stamp = out_stamp;
			got.body.res = out_resource; got.body.cooldown = out_cooldown;
			got.body.owner = out_owner; got.last = last;
			if (pending_msgs.size() == 0) begin
				want = '0;
				note_mismatch("unexpected message", want, got);
			end else begin
				want = pending_msgs.pop_front();
				if (got.body.kind != want.body.kind || got.body.dest != want.body.dest ||
						got.body.stamp != want.body.stamp || got.body.res != want.body.res ||
						got.body.cooldown != want.body.cooldown ||
						got.body.owner != want.body.owner || got.last != want.last)
					note_mismatch("field", want, got);
			end
		end
	end

	// Watchdog: any transfer on any channel resets the count.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 0; op = 0; src = 0; stamp = 0; resource = 0;
		cooldown_value = 0; cooldown_node = 0; fallback_resource = 0;
		stay_length = 0; cooldown_draw = 0;
		out_stall = 0; cfg_valid = 0; cfg_index = 0; cfg_data = 0;
		mismatches = 0; items_sent = 0; steady = 0; quiet_cycles = 0;
		holdoff_req = 0; holdoff_seen = 0; holdoff_left = 0;
		my_id = 0; n_nodes = 4; n_res = 4;
		lamport = 0; entry_clk = 0; hold_len = 0;
		go_idle();
		for (int r = 0; r < NRES; r++) begin
			cd_left[r] = 0;
			cd_holder[r] = -1;
			wait_cnt[r] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_queue_overflow();
		test_backpressure();
		test_config_sweep();
		test_random();

		wait_drained();
		if (mismatches == 0 && pending_msgs.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

/* files.f */
src/lma_pkg.sv
src/lma_ctrl.sv
src/lma_dp.sv
src/lamport_mutex_agent.sv
src/lma_checker.sv
dv/lamport_mutex_agent_test.sv
